[rtl/itp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg
// Shared constants, character codes and the operator precedence function
// for the infix to postfix converter.
// ----------------------------------------------------------------------------
package itp_pkg;

  // operator stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  // ascii codes
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // precedence levels
  typedef logic [1:0] prec_t;
  localparam prec_t PREC_MUL  = 2'd3;
  localparam prec_t PREC_ADD  = 2'd2;
  localparam prec_t PREC_NONE = 2'd0;

  function automatic prec_t prec_of(input logic [7:0] c);
    prec_t p;
    if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) begin
      p = PREC_MUL;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      p = PREC_ADD;
    end else begin
      p = PREC_NONE;
    end
    return p;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

[rtl/infix_to_postfix_converter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// Shunting-yard converter: infix characters in, postfix characters out,
// operators held on a small stack and popped by one shared compare unit.
// ----------------------------------------------------------------------------
// Takes one infix character per input beat and produces zero or more postfix
// beats, one per cycle while the output is not stalled, through a single
// output register. A digit, a dot in a number, or a character that only pushes
// is taken without a pop sequence; the space that closes a number leaves in the
// cycle the character is taken. Every operator popped from the stack leaves as
// two beats, the operator and its trailing space, in POP_OP and then POP_SP,
// since both leave through the one output register; the precedence compare
// against the next stack top runs in POP_SP. Output stalls hold the pops. The
// input is stalled while a pop sequence runs. The stack lives in flip-flops and
// needs no clearing after reset; a push into a full stack is dropped and raises
// the sticky overflow flag, which an end-of-expression flush clears.
module infix_to_postfix_converter_core
  import itp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       end_of_expression,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last_of_run,
  output logic       expression_done,
  output logic       overflow_flag
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_OP,
    ST_POP_SP
  } state_t;

  typedef enum logic [1:0] {
    MODE_END,
    MODE_RPAR,
    MODE_PUSH,
    MODE_OP
  } mode_t;

  // shared compare unit: does the current item pop the stack top
  function automatic logic pop_check(input mode_t m, input prec_t p,
                                     input logic [CNT_W-1:0] cnt,
                                     input logic [7:0] top);
    logic r;
    unique case (m)
      MODE_END:  r = (cnt != '0);
      MODE_RPAR: r = (cnt != '0) && (top != CH_LPAR);
      MODE_OP:   r = (cnt != '0) && (p <= prec_of(top));
      MODE_PUSH: r = 1'b0;
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

  state_t           state, state_next;
  mode_t            mode, mode_next;
  logic [7:0]       cur_char, cur_char_next;
  prec_t            cur_prec, cur_prec_next;
  logic [CNT_W-1:0] count, count_next;
  logic             in_number, in_number_next;
  logic             ovf_seen, ovf_seen_next;
  logic             run_ovf, run_ovf_next;

  logic [7:0]       stack [STACK_DEPTH];
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] top_idx;
  logic [7:0]       top;

  logic             in_acc;
  logic             can_emit;
  mode_t            in_mode;
  prec_t            in_prec;
  logic             pc;
  logic             will_ovf;

  logic             emit_en;
  logic [7:0]       emit_char;
  logic             emit_last;
  logic             emit_done;
  logic             emit_ovf;

  logic             tail_en;
  mode_t            tail_mode;
  logic [7:0]       tail_char;
  logic             push_en;

  // stack top read
  assign count_m1 = count - CNT_W'(1);
  assign top_idx  = count_m1[IDX_W-1:0];
  assign top      = stack[top_idx];

  // handshake
  assign can_emit = !out_valid || !out_stall;
  assign in_stall = rst || (state != ST_IDLE) || !can_emit;
  assign in_acc   = in_valid && !in_stall;

  // classify the incoming character
  always_comb begin
    in_prec = prec_of(in_char);
    priority if (end_of_expression) begin
      in_mode = MODE_END;
    end else if (in_char == CH_RPAR) begin
      in_mode = MODE_RPAR;
    end else if (in_char == CH_LPAR) begin
      in_mode = MODE_PUSH;
    end else begin
      in_mode = MODE_OP;
    end
  end

  // sequencer next state
  always_comb begin
    state_next     = state;
    mode_next      = mode;
    cur_char_next  = cur_char;
    cur_prec_next  = cur_prec;
    count_next     = count;
    in_number_next = in_number;
    ovf_seen_next  = ovf_seen;
    run_ovf_next   = run_ovf;
    emit_en        = 1'b0;
    emit_char      = CH_SPACE;
    emit_last      = 1'b0;
    emit_done      = 1'b0;
    emit_ovf       = run_ovf;
    tail_en        = 1'b0;
    tail_mode      = mode;
    tail_char      = cur_char;
    push_en        = 1'b0;
    pc             = 1'b0;
    will_ovf       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          pc            = pop_check(in_mode, in_prec, count, top);
          mode_next     = in_mode;
          cur_char_next = in_char;
          cur_prec_next = in_prec;
          priority if (end_of_expression) begin
            // flush: close number, then pop everything
            emit_ovf       = ovf_seen;
            run_ovf_next   = ovf_seen;
            ovf_seen_next  = 1'b0;
            in_number_next = 1'b0;
            if (in_number) begin
              emit_en   = 1'b1;
              emit_last = !pc;
              emit_done = !pc;
            end
            if (pc) begin
              state_next = ST_POP_OP;
            end
          end else if (is_digit(in_char)) begin
            emit_en        = 1'b1;
            emit_char      = in_char;
            emit_last      = 1'b1;
            emit_ovf       = ovf_seen;
            in_number_next = 1'b1;
          end else if (in_char == CH_DOT && in_number) begin
            emit_en   = 1'b1;
            emit_char = in_char;
            emit_last = 1'b1;
            emit_ovf  = ovf_seen;
          end else begin
            // operator or other character
            will_ovf = (in_mode == MODE_OP || in_mode == MODE_PUSH) && !pc &&
                       (count == CNT_W'(STACK_DEPTH));
            emit_ovf       = ovf_seen || will_ovf;
            run_ovf_next   = ovf_seen || will_ovf;
            ovf_seen_next  = ovf_seen || will_ovf;
            in_number_next = 1'b0;
            if (in_number) begin
              emit_en   = 1'b1;
              emit_last = !pc;
            end
            if (pc) begin
              state_next = ST_POP_OP;
            end else begin
              tail_en   = 1'b1;
              tail_mode = in_mode;
              tail_char = in_char;
            end
          end
        end
      end
      ST_POP_OP: begin
        if (can_emit) begin
          emit_en    = 1'b1;
          emit_char  = top;
          count_next = count_m1;
          state_next = ST_POP_SP;
        end
      end
      ST_POP_SP: begin
        if (can_emit) begin
          pc        = pop_check(mode, cur_prec, count, top);
          emit_en   = 1'b1;
          emit_last = !pc;
          emit_done = !pc && (mode == MODE_END);
          if (pc) begin
            state_next = ST_POP_OP;
          end else begin
            tail_en    = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // closing action once popping is over
    if (tail_en) begin
      unique case (tail_mode)
        MODE_PUSH, MODE_OP: begin
          if (count < CNT_W'(STACK_DEPTH)) begin
            push_en    = 1'b1;
            count_next = count + CNT_W'(1);
          end
        end
        MODE_RPAR: begin
          if (count != '0) begin
            count_next = count_m1;
          end
        end
        MODE_END: begin
        end
        default: begin
        end
      endcase
    end
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      in_number <= 1'b0;
      ovf_seen  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      in_number <= in_number_next;
      ovf_seen  <= ovf_seen_next;
      if (emit_en) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
    mode     <= mode_next;
    cur_char <= cur_char_next;
    cur_prec <= cur_prec_next;
    run_ovf  <= run_ovf_next;
    if (emit_en) begin
      out_char        <= emit_char;
      last_of_run     <= emit_last;
      expression_done <= emit_done;
      overflow_flag   <= emit_ovf;
    end
  end

  // operator stack write
  always_ff @(posedge clk) begin
    if (push_en) begin
      stack[count[IDX_W-1:0]] <= tail_char;
    end
  end

endmodule

[rtl/itp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks for the infix to postfix converter, bound to the top.
// ----------------------------------------------------------------------------
module itp_checker
  import itp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_char,
  input logic       end_of_expression,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       last_of_run,
  input logic       expression_done,
  input logic       overflow_flag
);

  // nothing on the output right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) &&
      $stable(last_of_run) && $stable(expression_done) && $stable(overflow_flag))
    else $error("stalled output beat changed");

  // the end of a flush is also the last beat of its run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && expression_done |-> last_of_run)
    else $error("expression_done without last_of_run");

  // a digit passes straight through as a single beat
  a_digit_pass: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !end_of_expression && is_digit(in_char) |=>
      out_valid && (out_char == $past(in_char)) && last_of_run && !expression_done)
    else $error("digit beat not passed through");

endmodule

bind infix_to_postfix_converter_core itp_checker u_itp_checker (.*);

[sim/tb_infix_to_postfix_converter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter_core
// Self-checking bench for the shunting-yard infix to postfix converter.
// Input beats are mirrored into a local operator-stack model that builds the
// expected postfix beats; every output beat is checked field by field against
// the oldest one. Directed expressions, a stack overflow case, a long output
// hold-off and a random expression phase run with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_converter_core
  import itp_pkg::*;
();

  localparam int TOTAL_ITEMS  = 330;
  localparam int QUIET_TAIL   = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       done;
    logic       ovf;
  } postfix_beat_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char;
  logic       end_of_expression;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic       last_of_run;
  logic       expression_done;
  logic       overflow_flag;

  // bench control
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  // operator stack model
  logic [7:0]    op_stack [STACK_DEPTH];
  int            op_count = 0;
  bit            in_number = 1'b0;
  bit            ovf_sticky = 1'b0;
  postfix_beat_t run_q[$];
  postfix_beat_t postfix_q[$];

  infix_to_postfix_converter_core dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char           (in_char),
    .end_of_expression (end_of_expression),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_char          (out_char),
    .last_of_run       (last_of_run),
    .expression_done   (expression_done),
    .overflow_flag     (overflow_flag)
  );

  // clock
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // postfix model
  // ---------------------------------------------------------------------------
  function automatic int op_rank(input logic [7:0] c);
    int r;
    if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) begin
      r = 3;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      r = 2;
    end else begin
      r = 0;
    end
    return r;
  endfunction

  task automatic add_char(input logic [7:0] c);
    postfix_beat_t b;
    b = '{ch: c, last: 1'b0, done: 1'b0, ovf: 1'b0};
    run_q.push_back(b);
  endtask

  task automatic pop_operator();
    op_count--;
    add_char(op_stack[op_count]);
    add_char(CH_SPACE);
  endtask

  task automatic push_operator(input logic [7:0] c);
    if (op_count >= STACK_DEPTH) begin
      ovf_sticky = 1'b1;
    end else begin
      op_stack[op_count] = c;
      op_count++;
    end
  endtask

  task automatic predict_postfix(input logic [7:0] c, input logic eoe);
    int r;
    run_q.delete();
    if (eoe) begin
      if (in_number) begin
        add_char(CH_SPACE);
        in_number = 1'b0;
      end
      while (op_count > 0) pop_operator();
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      add_char(c);
      in_number = 1'b1;
    end else if (c == CH_DOT && in_number) begin
      add_char(c);
    end else begin
      if (in_number) begin
        add_char(CH_SPACE);
        in_number = 1'b0;
      end
      if (c == CH_LPAR) begin
        push_operator(c);
      end else if (c == CH_RPAR) begin
        while (op_count > 0 && op_stack[op_count-1] != CH_LPAR) pop_operator();
        if (op_count > 0) op_count--;
      end else begin
        r = op_rank(c);
        while (op_count > 0 && r <= op_rank(op_stack[op_count-1])) pop_operator();
        push_operator(c);
      end
    end
    // run flags, then queue the whole run
    foreach (run_q[k]) run_q[k].ovf = ovf_sticky;
    if (run_q.size() > 0) begin
      run_q[run_q.size()-1].last = 1'b1;
      run_q[run_q.size()-1].done = eoe;
    end
    foreach (run_q[k]) postfix_q.push_back(run_q[k]);
    if (eoe) ovf_sticky = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // monitors
  // ---------------------------------------------------------------------------
  task automatic report_fail(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // accepted input beats feed the model
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) predict_postfix(in_char, end_of_expression);
  end

  // accepted output beats are checked against the oldest expectation
  always @(posedge clk) begin
    postfix_beat_t want;
    postfix_beat_t got;
    if (!rst && out_valid && !out_stall) begin
      got = '{ch: out_char, last: last_of_run, done: expression_done, ovf: overflow_flag};
      if (postfix_q.size() == 0) begin
        report_fail($sformatf("unexpected beat: char %02h last %0d done %0d ovf %0d",
                              got.ch, got.last, got.done, got.ovf));
      end else begin
        want = postfix_q.pop_front();
        if (got != want) begin
          report_fail($sformatf(
            "mismatch: exp ch %02h l%0d d%0d o%0d, got ch %02h l%0d d%0d o%0d",
            want.ch, want.last, want.done, want.ovf, got.ch, got.last, got.done, got.ovf));
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // output side: random stall bursts, or one long hold-off on request
  always begin
    @(posedge clk);
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_stall <= 1'b0;
      hold_req = 1'b0;
    end else if (!rst && idle_on && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] c, input logic eoe);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_char           <= c;
    end_of_expression <= eoe;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_beat(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // random byte now and then
  task automatic maybe_noise();
    if ($urandom_range(0, 11) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic send_number();
    int digits;
    digits = $urandom_range(1, 3);
    for (int i = 0; i < digits; i++) send_beat(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
    if ($urandom_range(0, 3) == 0) begin
      send_beat(CH_DOT, 1'b0);
      send_beat(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
    end
  endtask

  task automatic send_operator();
    case ($urandom_range(0, 6))
      0: send_beat(CH_PLUS, 1'b0);
      1: send_beat(CH_MINUS, 1'b0);
      2: send_beat(CH_STAR, 1'b0);
      3: send_beat(CH_SLASH, 1'b0);
      4: send_beat(CH_PCT, 1'b0);
      5: send_beat("^", 1'b0);
      default: send_beat(CH_SPACE, 1'b0);
    endcase
  endtask

  // one random expression, mostly well formed
  task automatic send_expression();
    int terms;
    int open;
    terms = $urandom_range(1, 6);
    open  = 0;
    for (int t = 0; t < terms; t++) begin
      while (open < 20 && $urandom_range(0, 3) == 0) begin
        send_beat(CH_LPAR, 1'b0);
        open++;
      end
      maybe_noise();
      send_number();
      while (open > 0 && $urandom_range(0, 2) == 0) begin
        send_beat(CH_RPAR, 1'b0);
        open--;
      end
      maybe_noise();
      if (t < terms - 1) send_operator();
    end
    // leave some parens unclosed
    while (open > 0) begin
      if ($urandom_range(0, 3) != 0) send_beat(CH_RPAR, 1'b0);
      open--;
    end
    if ($urandom_range(0, 7) != 0) send_end();
  endtask

  task automatic run_directed();
    // precedence, parens and a decimal number
    send_text("12.5+3*(4-1)");
    send_end();
    // modulo, plain character popping a paren, stray dot, unbalanced close
    send_text("9%(x)/.)");
    send_end();
    // byte extremes, end with a set char, then an empty flush
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b1);
  endtask

  task automatic run_overflow();
    // number closed by a paren, then pushes past the stack depth
    send_beat("5", 1'b0);
    for (int i = 0; i < STACK_DEPTH + 3; i++) send_beat(CH_LPAR, 1'b0);
    send_beat("N", 1'b0);
    send_beat("7", 1'b0);
    send_end();
    // sticky flag must be clear again
    send_text("1+2");
    send_end();
  endtask

  task automatic run_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) send_text("1*2-3/4+5%6");
    send_end();
    while (hold_req) @(posedge clk);
  endtask

  task automatic run_random();
    while (items_sent < TOTAL_ITEMS) begin
      // one quiet stretch in the middle and a quiet tail
      idle_on = (items_sent < TOTAL_ITEMS - QUIET_TAIL) &&
                !(items_sent >= 180 && items_sent < 210);
      send_expression();
    end
    send_end();
  endtask

  initial begin
    rst               <= 1'b1;
    in_valid          <= 1'b0;
    in_char           <= 8'h00;
    end_of_expression <= 1'b0;
    out_stall         <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_overflow();
    run_backpressure();
    run_random();
    in_valid <= 1'b0;

    // drain and watch for stray beats
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && postfix_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
